// File: hdl/bta_pkg.sv
// Shared types, constants and helpers for the beat tracker agent.
// No dependencies; every other file in hdl/ imports this package.
package bta_pkg;

  // Default window half width bound (top-level parameter default)
  localparam int BTA_MAX_TOL = 15;

  // Field widths
  localparam int FRAME_W = 32;
  localparam int POWER_W = 16;
  localparam int REL_W   = 24;
  localparam int PHASE_W = 16;
  localparam int INTV_W  = 10;
  localparam int TOL_W   = 4;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PHASE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOL      = 2'd2;

  // Reset values of the configuration registers
  localparam logic [PHASE_W-1:0] CFG_PHASE_RST    = 16'd0;
  localparam logic [INTV_W-1:0]  CFG_INTERVAL_RST = 10'd50;
  localparam logic [TOL_W-1:0]   CFG_TOL_RST      = 4'd4;

  // 0.1 in Q4.12
  localparam logic [POWER_W-1:0] STRONG_LEVEL = 16'd410;
  // Divisor for the 0.8 decay: rel * 4 / 5
  localparam logic [POWER_W-1:0] DECAY_DIV = 16'd5;

  typedef struct packed {
    logic [PHASE_W-1:0] start_phase;
    logic [INTV_W-1:0]  beat_interval;
    logic [TOL_W-1:0]   tolerance;
  } bta_cfg_t;

  // One item as it travels from front to back
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [POWER_W-1:0] power;
    logic [POWER_W-1:0] runmax;     // running max including this item
    logic               first;      // first item after reset
    logic [FRAME_W-1:0] init_pred;  // phase + interval, used when first
  } bta_item_t;

  typedef struct packed {
    logic               valid;
    logic               window_closed;
    logic               strong_peak;
    logic [FRAME_W-1:0] beat_frame;
    logic [FRAME_W-1:0] next_prediction;
    logic [REL_W-1:0]   reliability;
  } bta_result_t;

  // A zero interval acts as one
  function automatic logic [INTV_W-1:0] bta_interval(input logic [INTV_W-1:0] raw);
    return (raw == '0) ? INTV_W'(1) : raw;
  endfunction

endpackage

// File: hdl/bta_front.sv
// Input side: accepts items, tracks the running maximum and the first item.
// Depends on bta_pkg; feeds bta_queue.
module bta_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bta_pkg::bta_cfg_t          cfg,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [bta_pkg::FRAME_W-1:0] in_frame_number,
  input  logic [bta_pkg::POWER_W-1:0] in_onset_power,
  input  logic                       q_full,
  output logic                       q_push,
  output bta_pkg::bta_item_t         q_item
);
  import bta_pkg::*;

  logic               started_r;
  logic [POWER_W-1:0] runmax_r;
  logic [POWER_W-1:0] runmax_nxt;
  logic [PHASE_W:0]   init_sum;

  assign in_stall   = q_full;
  assign q_push     = in_valid && !q_full;
  assign runmax_nxt = (in_onset_power > runmax_r) ? in_onset_power : runmax_r;
  assign init_sum   = {1'b0, cfg.start_phase}
                    + (PHASE_W+1)'(bta_interval(cfg.beat_interval));

  always_comb begin
    q_item.frame     = in_frame_number;
    q_item.power     = in_onset_power;
    q_item.runmax    = runmax_nxt;
    q_item.first     = !started_r;
    q_item.init_pred = FRAME_W'(init_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      runmax_r  <= '0;
    end else if (q_push) begin
      started_r <= 1'b1;
      runmax_r  <= runmax_nxt;
    end
  end

endmodule

// File: hdl/bta_queue.sv
// Two-entry queue of items between the front and the back.
// Depends on bta_pkg for the item type.
module bta_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bta_pkg::bta_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output bta_pkg::bta_item_t pop_item
);
  import bta_pkg::*;

  bta_item_t  mem_r [2];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_item  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= !wptr_r;
      if (pop)  rptr_r <= !rptr_r;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: hdl/bta_back.sv
// Execution side: window store, window argmax scan, beat update and a
// radix-4 restoring divider for the reliability update. Depends on bta_pkg.
module bta_back #(
  parameter int MAX_TOLERANCE = bta_pkg::BTA_MAX_TOL
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bta_pkg::bta_cfg_t   cfg,
  input  logic                q_vld,
  input  bta_pkg::bta_item_t  q_item,
  output logic                q_pop,
  input  logic                out_stall,
  output bta_pkg::bta_result_t res
);
  import bta_pkg::*;

  localparam int Depth  = 2 * MAX_TOLERANCE + 1;
  localparam int AW     = $clog2(Depth);
  localparam int TolCap = (MAX_TOLERANCE < 15) ? MAX_TOLERANCE : 15;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_SCAN, S_PICK, S_NEXT, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t             state_r;
  bta_item_t          item_r;
  logic [FRAME_W-1:0] pred_r;
  logic [FRAME_W-1:0] last_r;
  logic [REL_W-1:0]   rel_r;
  logic [Depth-1:0]   vld_r;
  logic [POWER_W-1:0] mem [Depth];
  logic [POWER_W-1:0] rd_data_r;
  logic               rd_vld_r;
  logic [AW-1:0]      iss_r;
  logic               iss_done_r;
  logic               cmp_vld_r;
  logic [AW-1:0]      cmp_idx_r;
  logic [POWER_W-1:0] best_r;
  logic [AW-1:0]      bidx_r;
  logic               strong_r;
  logic [31:0]        dq_r;
  logic [15:0]        rem_r;
  logic [15:0]        dvsr_r;
  logic [3:0]         dcnt_r;

  logic [TOL_W-1:0]   tol_eff;
  logic [INTV_W-1:0]  intv_eff;
  logic [AW-1:0]      last_idx;
  logic [33:0]        rest;
  logic               in_win;
  logic [AW-1:0]      wr_pos;
  logic [POWER_W-1:0] rd_val;
  logic [8:0]         off9;
  logic [FRAME_W-1:0] peak;
  logic [47:0]        step1;
  logic [47:0]        step2;
  logic [REL_W:0]     sum25;
  logic [REL_W-1:0]   rel_nxt;

  // one restoring division step: {rem, dividend/quotient}
  function automatic logic [47:0] div_step(input logic [15:0] rem,
                                           input logic [31:0] dq,
                                           input logic [15:0] d);
    logic [16:0] t;
    logic [16:0] diff;
    begin
      t    = {rem, dq[31]};
      diff = t - {1'b0, d};
      if (!diff[16]) return {diff[15:0], dq[30:0], 1'b1};
      else           return {t[15:0], dq[30:0], 1'b0};
    end
  endfunction

  assign tol_eff  = (int'(cfg.tolerance) > TolCap) ? TOL_W'(TolCap) : cfg.tolerance;
  assign intv_eff = bta_interval(cfg.beat_interval);
  assign last_idx = AW'({2'b00, tol_eff, 1'b0});

  // distance from this frame to the window end; window is 0..2*tol
  assign rest   = {2'b00, pred_r} + 34'(tol_eff) - {2'b00, item_r.frame};
  assign in_win = !rest[33] && (rest[32:0] <= 33'(last_idx));
  assign wr_pos = last_idx - AW'(rest);

  assign rd_val = rd_vld_r ? rd_data_r : '0;
  assign off9   = 9'(bidx_r) - 9'(tol_eff);
  assign peak   = (bidx_r == '0) ? pred_r : pred_r + {{(FRAME_W-9){off9[8]}}, off9};

  assign step1 = div_step(rem_r, dq_r, dvsr_r);
  assign step2 = div_step(step1[47:32], step1[31:0], dvsr_r);

  assign sum25 = {1'b0, rel_r} + {1'b0, dq_r[REL_W-1:0]};
  always_comb begin
    if (!strong_r)            rel_nxt = dq_r[REL_W-1:0];
    else if (dvsr_r == '0)    rel_nxt = rel_r;
    else if ((|dq_r[31:REL_W]) || sum25[REL_W]) rel_nxt = '1;
    else                      rel_nxt = sum25[REL_W-1:0];
  end

  assign q_pop = (state_r == S_IDLE) && q_vld;

  // window store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state_r == S_CHECK && in_win) mem[wr_pos] <= item_r.power;
    rd_data_r <= mem[iss_r];
    rd_vld_r  <= vld_r[iss_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pred_r     <= '0;
      last_r     <= '0;
      rel_r      <= '0;
      vld_r      <= '0;
      iss_r      <= '0;
      iss_done_r <= 1'b0;
      cmp_vld_r  <= 1'b0;
      res.valid  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_vld) begin
            item_r <= q_item;
            if (q_item.first) pred_r <= q_item.init_pred;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (in_win) vld_r[wr_pos] <= 1'b1;
          if (rest == '0) begin
            iss_r      <= '0;
            iss_done_r <= 1'b0;
            cmp_vld_r  <= 1'b0;
            best_r     <= '0;
            bidx_r     <= '0;
            state_r    <= S_SCAN;
          end else begin
            res.valid           <= 1'b1;
            res.window_closed   <= 1'b0;
            res.strong_peak     <= 1'b0;
            res.beat_frame      <= last_r;
            res.next_prediction <= pred_r;
            res.reliability     <= rel_r;
            state_r             <= S_OUT;
          end
        end
        S_SCAN: begin
          cmp_vld_r <= !iss_done_r;
          cmp_idx_r <= iss_r;
          if (!iss_done_r) begin
            if (iss_r == last_idx) iss_done_r <= 1'b1;
            else                   iss_r <= iss_r + AW'(1);
          end
          if (cmp_vld_r) begin
            // first strict maximum wins
            if (rd_val > best_r) begin
              best_r <= rd_val;
              bidx_r <= cmp_idx_r;
            end
            if (cmp_idx_r == last_idx) state_r <= S_PICK;
          end
        end
        S_PICK: begin
          last_r   <= peak;
          strong_r <= (best_r >= STRONG_LEVEL);
          rem_r    <= '0;
          dcnt_r   <= '0;
          if (best_r >= STRONG_LEVEL) begin
            dq_r   <= {best_r, 16'd0};
            dvsr_r <= item_r.runmax;
          end else begin
            dq_r   <= {6'd0, rel_r, 2'b00};
            dvsr_r <= DECAY_DIV;
          end
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          pred_r  <= last_r + FRAME_W'(intv_eff);
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r  <= step2[47:32];
          dq_r   <= step2[31:0];
          dcnt_r <= dcnt_r + 4'd1;
          if (dcnt_r == 4'd15) state_r <= S_FIN;
        end
        S_FIN: begin
          rel_r               <= rel_nxt;
          res.valid           <= 1'b1;
          res.window_closed   <= 1'b1;
          res.strong_peak     <= strong_r;
          res.beat_frame      <= last_r;
          res.next_prediction <= pred_r;
          res.reliability     <= rel_nxt;
          state_r             <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            res.valid <= 1'b0;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/beat_tracker_agent_core.sv
// Top level of the beat tracker agent: configuration registers, front,
// item queue and back. Depends on bta_pkg, bta_front, bta_queue, bta_back.
//
//  channel  | valid     | stall      | payload
//  ---------+-----------+------------+---------------------------------------
//  input    | in_valid  | in_stall   | in_frame_number, in_onset_power
//  result   | out_valid | out_stall  | out_window_closed, out_strong_peak,
//           |           |            | out_beat_frame, out_next_prediction,
//           |           |            | out_reliability_out
//  config   | cfg_we    | -          | cfg_index, cfg_wdata
//
// An item that does not close a window passes the back through pop,
// window check with store write and result load, and hand-off. An item
// that closes a window adds the argmax scan through the store's single
// read port, pick and prediction steps, the 2-bit-per-cycle divider and
// the result load; a stalled result holds the back in hand-off.
// Reset is synchronous, active low; it clears control state, the window
// store's valid bits and restores the register defaults. The front keeps
// accepting into a two-entry queue while the back works or a result is
// stalled; in_stall rises only when that queue is full.
module beat_tracker_agent_core #(
  parameter int MAX_TOLERANCE = bta_pkg::BTA_MAX_TOL
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic [bta_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bta_pkg::CFG_W-1:0]     cfg_wdata,
  // input items
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bta_pkg::FRAME_W-1:0]   in_frame_number,
  input  logic [bta_pkg::POWER_W-1:0]   in_onset_power,
  // result items
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_window_closed,
  output logic                         out_strong_peak,
  output logic [bta_pkg::FRAME_W-1:0]   out_beat_frame,
  output logic [bta_pkg::FRAME_W-1:0]   out_next_prediction,
  output logic [bta_pkg::REL_W-1:0]     out_reliability_out
);
  import bta_pkg::*;

  bta_cfg_t    cfg_r;
  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_vld;
  bta_item_t   push_item;
  bta_item_t   pop_item;
  bta_result_t res;

  // Register file; writes are expected only while no item is in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_phase   <= CFG_PHASE_RST;
      cfg_r.beat_interval <= CFG_INTERVAL_RST;
      cfg_r.tolerance     <= CFG_TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_PHASE:    cfg_r.start_phase   <= cfg_wdata[PHASE_W-1:0];
        CFG_IDX_INTERVAL: cfg_r.beat_interval <= cfg_wdata[INTV_W-1:0];
        CFG_IDX_TOL:      cfg_r.tolerance     <= cfg_wdata[TOL_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // Front: handshake, running max, first-item prediction seed
  bta_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_frame_number (in_frame_number),
    .in_onset_power  (in_onset_power),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (push_item)
  );

  bta_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_vld),
    .pop_item  (pop_item)
  );

  // Back: window store, scan, beat/prediction and reliability update
  bta_back #(
    .MAX_TOLERANCE (MAX_TOLERANCE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_vld     (q_vld),
    .q_item    (pop_item),
    .q_pop     (q_pop),
    .out_stall (out_stall),
    .res       (res)
  );

  // Result register lives in the back; held stable while stalled
  assign out_valid           = res.valid;
  assign out_window_closed   = res.window_closed;
  assign out_strong_peak     = res.strong_peak;
  assign out_beat_frame      = res.beat_frame;
  assign out_next_prediction = res.next_prediction;
  assign out_reliability_out = res.reliability;

endmodule

// File: bench/beat_track_checker.sv
// Checker for the beat tracker agent: follows cfg writes and accepted items,
// predicts each result item, and compares the result channel field by field.
// Depends on bta_pkg for widths, register indexes and the strong-peak level.
`timescale 1ns / 1ps

module beat_track_checker #(
  parameter int MAX_TOL = bta_pkg::BTA_MAX_TOL
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bta_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bta_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [bta_pkg::FRAME_W-1:0]   in_frame_number,
  input  logic [bta_pkg::POWER_W-1:0]   in_onset_power,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_window_closed,
  input  logic                          out_strong_peak,
  input  logic [bta_pkg::FRAME_W-1:0]   out_beat_frame,
  input  logic [bta_pkg::FRAME_W-1:0]   out_next_prediction,
  input  logic [bta_pkg::REL_W-1:0]     out_reliability_out,
  output int                            fail_count,
  output int                            pending_results,
  output int                            items_taken,
  output int                            windows_closed,
  output int                            strong_peaks,
  output logic [bta_pkg::FRAME_W-1:0]   model_pred
);
  import bta_pkg::*;

  localparam int DEPTH = 2 * MAX_TOL + 1;

  typedef struct packed {
    logic               closed;
    logic               strong_pk;
    logic [FRAME_W-1:0] beat;
    logic [FRAME_W-1:0] pred;
    logic [REL_W-1:0]   rel;
  } beat_update_t;

  // register copies
  logic [PHASE_W-1:0] phase_r;
  logic [INTV_W-1:0]  interval_r;
  logic [TOL_W-1:0]   tol_r;

  // tracker state
  logic               tracking;
  logic [FRAME_W-1:0] pred_frame;
  logic [FRAME_W-1:0] beat_at;
  logic [POWER_W-1:0] window_mem [DEPTH];
  logic [POWER_W-1:0] peak_max;
  logic [REL_W-1:0]   rel_acc;

  beat_update_t beat_updates_q[$];
  int           results_seen;

  initial begin
    fail_count      = 0;
    pending_results = 0;
    items_taken     = 0;
    windows_closed  = 0;
    strong_peaks    = 0;
    results_seen    = 0;
  end

  assign model_pred = pred_frame;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: result %0d %s: got %0h, want %0h", $time, results_seen, what, got, want);
    fail_count++;
  endtask

  // One frame through the tracker: store, window close, beat and reliability.
  task automatic track_frame(input logic [FRAME_W-1:0] frame,
                             input logic [POWER_W-1:0] power,
                             output beat_update_t upd);
    int                 tol;
    int                 slot;
    int                 best_at;
    int                 i;
    longint             to_end;
    logic [INTV_W-1:0]  step;
    logic [POWER_W-1:0] best;
    logic [FRAME_W-1:0] peak;
    logic [31:0]        inc;
    logic [31:0]        sum;
    tol  = (int'(tol_r) > MAX_TOL) ? MAX_TOL : int'(tol_r);
    step = (interval_r == '0) ? INTV_W'(1) : interval_r;
    upd  = '0;
    if (!tracking) begin
      pred_frame = FRAME_W'(phase_r) + FRAME_W'(step);
      tracking   = 1'b1;
    end
    if (power > peak_max) peak_max = power;
    // distance to the window's far edge, no wrap
    to_end = longint'(pred_frame) + longint'(tol) - longint'(frame);
    if (to_end >= 0 && to_end <= 2 * tol) begin
      slot = 2 * tol - int'(to_end);
      if (slot < DEPTH) window_mem[slot] = power;
    end
    if (to_end == 0) begin
      best    = '0;
      best_at = 0;
      for (i = 0; i <= 2 * tol && i < DEPTH; i++) begin
        if (window_mem[i] > best) begin
          best    = window_mem[i];
          best_at = i;
        end
      end
      peak = (best_at == 0) ? pred_frame
                            : pred_frame - FRAME_W'(tol) + FRAME_W'(best_at);
      beat_at    = peak;
      pred_frame = peak + FRAME_W'(step);
      upd.closed = 1'b1;
      if (best < STRONG_LEVEL) begin
        rel_acc = REL_W'((32'(rel_acc) * 32'd4) / 32'd5);
      end else begin
        upd.strong_pk = 1'b1;
        inc = (peak_max != '0) ? ((32'(best) << 16) / 32'(peak_max)) : 32'd0;
        sum = 32'(rel_acc) + inc;
        rel_acc = (sum > 32'(24'hFF_FFFF)) ? '1 : sum[REL_W-1:0];
      end
    end
    upd.beat = beat_at;
    upd.pred = pred_frame;
    upd.rel  = rel_acc;
  endtask

  always @(posedge clk) begin : watch
    beat_update_t want;
    beat_update_t fresh;
    int k;
    if (!rst_n) begin
      phase_r    = CFG_PHASE_RST;
      interval_r = CFG_INTERVAL_RST;
      tol_r      = CFG_TOL_RST;
      tracking   = 1'b0;
      pred_frame = '0;
      beat_at    = '0;
      peak_max   = '0;
      rel_acc    = '0;
      for (k = 0; k < DEPTH; k++) window_mem[k] = '0;
      beat_updates_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_PHASE:    phase_r    = cfg_wdata[PHASE_W-1:0];
          CFG_IDX_INTERVAL: interval_r = cfg_wdata[INTV_W-1:0];
          CFG_IDX_TOL:      tol_r      = cfg_wdata[TOL_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (beat_updates_q.size() == 0) begin
          report_mismatch("with no item pending, beat_frame", out_beat_frame, '0);
        end else begin
          want = beat_updates_q.pop_front();
          if (out_window_closed !== want.closed)
            report_mismatch("window_closed", 32'(out_window_closed), 32'(want.closed));
          if (out_strong_peak !== want.strong_pk)
            report_mismatch("strong_peak", 32'(out_strong_peak), 32'(want.strong_pk));
          if (out_beat_frame !== want.beat)
            report_mismatch("beat_frame", out_beat_frame, want.beat);
          if (out_next_prediction !== want.pred)
            report_mismatch("next_prediction", out_next_prediction, want.pred);
          if (out_reliability_out !== want.rel)
            report_mismatch("reliability_out", 32'(out_reliability_out), 32'(want.rel));
        end
      end
      if (in_valid && !in_stall) begin
        track_frame(in_frame_number, in_onset_power, fresh);
        beat_updates_q.push_back(fresh);
        items_taken++;
        if (fresh.closed) windows_closed++;
        if (fresh.strong_pk) strong_peaks++;
      end
    end
    pending_results = beat_updates_q.size();
  end

endmodule

// File: bench/tb_beat_tracker_agent_core.sv
// Top of the beat tracker agent bench: clock, reset, register writes and
// frame stimulus, plus the verdict. Depends on bta_pkg, beat_tracker_agent_core
// and beat_track_checker.
`timescale 1ns / 1ps

module tb_beat_tracker_agent_core;
  import bta_pkg::*;

  // unused register index, written to show it is ignored
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  // tail wait covers the slowest window close with margin
  localparam int TAIL_CYCLES  = 2 * BTA_MAX_TOL + 32;
  localparam int DRAIN_LIMIT  = 50000;
  localparam int NUM_PHASES   = 8;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [FRAME_W-1:0]   in_frame_number = '0;
  logic [POWER_W-1:0]   in_onset_power = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_window_closed;
  logic                 out_strong_peak;
  logic [FRAME_W-1:0]   out_beat_frame;
  logic [FRAME_W-1:0]   out_next_prediction;
  logic [REL_W-1:0]     out_reliability_out;

  int                   fail_count;
  int                   pending_results;
  int                   items_taken;
  int                   windows_closed;
  int                   strong_peaks;
  logic [FRAME_W-1:0]   model_pred;

  // idle percentages per cycle for each side; zero means never idle
  int                   send_pct = 0;
  int                   recv_pct = 0;
  // next frame to send, and the tolerance last written (for resync)
  logic [FRAME_W-1:0]   frame_q = '0;
  int                   cur_tol = 4;
  int                   settings_used = 1;

  always #2 clk = ~clk;

  beat_tracker_agent_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_frame_number     (in_frame_number),
    .in_onset_power      (in_onset_power),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_window_closed   (out_window_closed),
    .out_strong_peak     (out_strong_peak),
    .out_beat_frame      (out_beat_frame),
    .out_next_prediction (out_next_prediction),
    .out_reliability_out (out_reliability_out)
  );

  beat_track_checker checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_frame_number     (in_frame_number),
    .in_onset_power      (in_onset_power),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_window_closed   (out_window_closed),
    .out_strong_peak     (out_strong_peak),
    .out_beat_frame      (out_beat_frame),
    .out_next_prediction (out_next_prediction),
    .out_reliability_out (out_reliability_out),
    .fail_count          (fail_count),
    .pending_results     (pending_results),
    .items_taken         (items_taken),
    .windows_closed      (windows_closed),
    .strong_peaks        (strong_peaks),
    .model_pred          (model_pred)
  );

  // Receiver back-pressure: one fresh decision per cycle, off the falling edge.
  always @(negedge clk) begin
    out_stall <= (recv_pct > 0) && ($urandom_range(0, 99) < recv_pct);
  end

  // One register write; we drops on the next falling edge, so back-to-back
  // calls never toggle cfg_we twice in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Full register setting. Upper wdata bits beyond each register are random
  // so the masking gets exercised too.
  task automatic apply_setting(input logic [PHASE_W-1:0] phase,
                               input logic [INTV_W-1:0] intv,
                               input logic [TOL_W-1:0] tolv);
    logic [CFG_W-1:0] junk;
    junk = CFG_W'($urandom());
    write_reg(CFG_IDX_PHASE, phase);
    write_reg(CFG_IDX_INTERVAL, {junk[CFG_W-1:INTV_W], intv});
    write_reg(CFG_IDX_TOL, {junk[CFG_W-TOL_W-1:0], tolv});
    write_reg(CFG_IDX_SPARE, CFG_W'($urandom()));
    cur_tol = int'(tolv);
    settings_used++;
  endtask

  // Present one item and hold it until accepted. Entered and left on a
  // falling edge; a gap drops valid first, otherwise valid stays high.
  task automatic send_item(input logic [FRAME_W-1:0] frame, input logic [POWER_W-1:0] power);
    int gap;
    gap = 0;
    while ((send_pct > 0) && ($urandom_range(0, 99) < send_pct)) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_frame_number <= frame;
    in_onset_power  <= power;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid and wait for every result item; always spends at least one
  // falling edge so a following valid rise lands in a later step.
  task automatic drain;
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
  endtask

  // Random item. Mostly consecutive frames kept near the predicted window,
  // with some jumps, skips and steps back as noise.
  task automatic send_random(input bit hot, input int weak_pct);
    int unsigned        pick;
    logic [FRAME_W-1:0] diff;
    logic [POWER_W-1:0] pw;
    pick = $urandom_range(0, 99);
    if (pick == 0) begin
      frame_q = 32'hFFFF_FFFF - $urandom_range(0, 20);   // around the frame wrap
    end else if (pick < 4) begin
      frame_q = $urandom();
    end else if (pick < 6) begin
      frame_q = frame_q - $urandom_range(1, 40);
    end else if (pick < 8) begin
      frame_q = frame_q + $urandom_range(2, 40);
    end else begin
      diff = frame_q - model_pred;
      if (diff > FRAME_W'(cur_tol) && diff < 32'h8000_0000) begin
        // window already passed: about half the time pull back ahead of it
        if ($urandom_range(0, 1) == 1)
          frame_q = model_pred - FRAME_W'(cur_tol) - $urandom_range(0, 6);
      end else if (diff >= 32'h8000_0000 && diff < 32'hFFFF_FFC0) begin
        // far short of the window: skip ahead now and then
        if ($urandom_range(0, 3) == 0)
          frame_q = model_pred - FRAME_W'(cur_tol) - $urandom_range(0, 6);
      end
    end
    pick = $urandom_range(0, 99);
    if (hot) begin
      pw = POWER_W'($urandom_range(16'hE000, 16'hFFFF));   // drives saturation
    end else if (pick < weak_pct) begin
      pw = POWER_W'($urandom_range(0, 409));
    end else if (pick < weak_pct + 6) begin
      case ($urandom_range(0, 3))
        0:       pw = '0;
        1:       pw = STRONG_LEVEL - 16'd1;
        2:       pw = STRONG_LEVEL;
        default: pw = '1;
      endcase
    end else begin
      pw = POWER_W'($urandom());
    end
    send_item(frame_q, pw);
    frame_q = frame_q + 1;
  endtask

  // Watchdog: well beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int ph;
    int n;
    int i;
    int drain_wait;
    logic [INTV_W-1:0] intv;
    logic [TOL_W-1:0]  tolv;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed ----
    // Only the phase is written first, so the first item loads
    // phase + the default interval, with the default tolerance.
    write_reg(CFG_IDX_PHASE, 16'hFFFF);
    // First window 65581..65589: full-scale power at index 0, zeros after,
    // so the maximum sits at the window start and the beat stays put.
    send_item(32'd65581, 16'hFFFF);
    for (i = 1; i < 9; i++) send_item(32'd65581 + i, '0);
    drain();

    // Tiny window: interval 3, tolerance 1.
    apply_setting(16'h0000, 10'd3, 4'd1);
    // equal powers just under the level: first strict max at index 0, weak
    send_item(32'd65634, STRONG_LEVEL - 16'd1);
    send_item(32'd65635, STRONG_LEVEL - 16'd1);
    send_item(32'd65636, STRONG_LEVEL - 16'd1);
    // nothing above zero: beat stays, reliability decays
    send_item(32'd65637, '0);
    send_item(32'd65638, '0);
    send_item(32'd65639, '0);
    // peak at the last slot, exactly at the strong level: beat moves
    send_item(32'd65640, 16'd100);
    send_item(32'd65641, 16'd200);
    send_item(32'd65642, STRONG_LEVEL);
    // jump past the window and across the frame wrap: missed window
    send_item(32'hFFFF_FFFE, 16'h8000);
    send_item(32'hFFFF_FFFF, 16'h0001);
    send_item(32'h0000_0000, 16'h5555);
    send_item(32'h0000_0001, 16'hAAAA);
    frame_q = 32'h0000_0002;
    drain();

    // ---- random phases ----
    // Each phase gets its own setting (extremes included) and idle pattern.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       begin intv = 10'd0;    tolv = 4'd0;  end   // zero interval acts as one
        1:       begin intv = 10'd1;    tolv = 4'd15; end
        2:       begin intv = 10'd1023; tolv = 4'd15; end
        3:       begin intv = 10'd20;   tolv = 4'd4;  end
        4:       begin intv = INTV_W'($urandom_range(1, 63));
                       tolv = TOL_W'($urandom_range(0, 15)); end
        5:       begin intv = 10'd7;    tolv = 4'd3;  end
        6:       begin intv = INTV_W'($urandom_range(1, 1023));
                       tolv = TOL_W'($urandom_range(0, 15)); end
        default: begin intv = 10'd2;    tolv = 4'd1;  end
      endcase
      apply_setting(PHASE_W'($urandom()), intv, tolv);
      case (ph % 4)
        0:       begin send_pct = 0;  recv_pct = 0;  end
        1:       begin send_pct = 49; recv_pct = 0;  end
        2:       begin send_pct = 0;  recv_pct = 49; end
        default: begin send_pct = 33; recv_pct = 33; end
      endcase
      // phase 0 closes a window on nearly every frame with hot powers,
      // long enough to push reliability into saturation
      n = (ph == 0) ? 500 : 186;
      for (i = 0; i < n; i++) send_random(ph == 0, 30);
      drain();
      send_pct = 0;
      recv_pct = 0;
    end

    // ---- wrap-up ----
    in_valid <= 1'b0;
    drain_wait = 0;
    while (pending_results != 0 && drain_wait < DRAIN_LIMIT) begin
      @(negedge clk);
      drain_wait++;
    end
    if (pending_results != 0) begin
      $display("Mismatches found");
      $finish;
    end else begin
      // let any stray result item show up before the verdict
      repeat (TAIL_CYCLES) @(negedge clk);
      $display("Run covered %0d items under %0d register settings and four idle patterns.",
               items_taken, settings_used);
      $display("%0d prediction windows closed, %0d of them on a strong peak.",
               windows_closed, strong_peaks);
      if (fail_count == 0) begin
        $display("No mismatches found");
      end else begin
        $display("Mismatches found");
      end
      $finish;
    end
  end

endmodule

// File: beat_tracker_agent_core.f
hdl/bta_pkg.sv
hdl/bta_front.sv
hdl/bta_queue.sv
hdl/bta_back.sv
hdl/beat_tracker_agent_core.sv
bench/beat_track_checker.sv
bench/tb_beat_tracker_agent_core.sv
